>>> hdl/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg: shared types for the bounded double-ended queue
// Operation and status codes, transaction structs and the per-cell control
// bundle broadcast along the cell chain.
// ---------------------------------------------------------------------------
package dq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_INJECT = 2'd2,
        OP_EJECT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  value_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  value_out;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

    // Broadcast to every cell; at most one strobe is high per cycle
    typedef struct packed {
        logic               push;
        logic               pop;
        logic               inject;
        logic               eject;
        logic [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

>>> hdl/dq_cell.sv
// ---------------------------------------------------------------------------
// dq_cell: one storage cell of the deque chain
// Holds one word and its valid bit. Shifts towards the rear on push, towards
// the front on pop, captures on inject when it is the first free cell and
// empties on eject when it is the last occupied cell.
// ---------------------------------------------------------------------------
module dq_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dq_pkg::cell_ctrl_t         ctrl,
    input  logic [dq_pkg::DATA_W-1:0]  left_data,
    input  logic                       left_valid,
    input  logic [dq_pkg::DATA_W-1:0]  right_data,
    input  logic                       right_valid,
    output logic [dq_pkg::DATA_W-1:0]  data,
    output logic                       valid,
    output logic [dq_pkg::DATA_W-1:0]  tap
);
    import dq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;
    logic              is_rear;
    logic              is_free_head;

    assign is_rear      = valid_reg & ~right_valid;
    assign is_free_head = ~valid_reg & left_valid;

    // Next contents from the broadcast strobe
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        priority if (ctrl.push)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.pop)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.inject)
        begin
            if (is_free_head)
            begin
                data_next  = ctrl.value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.eject)
        begin
            if (is_rear)
                valid_next = 1'b0;
        end
    end

    // Valid bit is control state; the word itself needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    // Rear word offered for an eject; zero elsewhere so taps can be ORed
    assign tap   = is_rear ? data_reg : '0;

endmodule

>>> hdl/bounded_double_ended_queue.sv
// ---------------------------------------------------------------------------
// bounded_double_ended_queue: double-ended queue built from a cell chain
// Front element always sits in cell 0; elements are contiguous behind it.
// Push and pop shift the whole chain by one cell, inject and eject act on
// the boundary between occupied and free cells.
// ---------------------------------------------------------------------------
//  channel | signals                  | direction | transaction
//  req     | req_valid, req_stall, req | in        | one operation
//  rsp     | rsp_valid, rsp_stall, rsp | out       | one result per operation
//
//  One operation per cycle while req_stall is low: every cell updates in the cycle of acceptance,
//  and the result sits in a single output register the following cycle.
//  Reset empties the chain (valid bits cleared); no clearing pass is needed.
//  req_stall is high only while a result waits and rsp_stall holds it.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dq_pkg::req_t  req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dq_pkg::rsp_t  rsp
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [DATA_W-1:0] cell_data  [CAPACITY];
    logic [DATA_W-1:0] cell_tap   [CAPACITY];
    logic              cell_valid [CAPACITY];

    cell_ctrl_t        ctrl;
    logic              accept;
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] rear_word;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W+OCC_W-1:0] count_wide;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    // Handshake: take a transaction unless a result is held back
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    assign full  = cell_valid[CAPACITY-1];
    assign empty = ~cell_valid[0];

    // Strobes for the chain; refused operations leave the cells alone
    always_comb
    begin
        ctrl        = '0;
        ctrl.value  = req.value_in;
        if (accept)
        begin
            unique case (req.op)
                OP_PUSH:   ctrl.push   = ~full;
                OP_POP:    ctrl.pop    = ~empty;
                OP_INJECT: ctrl.inject = ~full;
                OP_EJECT:  ctrl.eject  = ~empty;
                default:   ctrl        = ctrl;
            endcase
        end
    end

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] l_data;
        logic              l_valid;
        logic [DATA_W-1:0] r_data;
        logic              r_valid;

        if (i == 0)
        begin : g_head
            assign l_data  = req.value_in;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        dq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tap         (cell_tap[i])
        );
    end

    // At most one cell offers its word as a tap, the rear one; all others give zero
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < CAPACITY; i++)
            rear_word = rear_word | cell_tap[i];
    end

    // Occupancy counter
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push || ctrl.inject)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.pop || ctrl.eject)
            count_next = count_reg - CNT_W'(1);
    end

    assign count_wide = {{OCC_W{1'b0}}, count_next};

    // Result for the accepted transaction
    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_next.value_out = '0;
        rsp_next.status    = ST_OK;
        rsp_next.occupancy = count_wide[OCC_W-1:0];
        unique case (req.op)
            OP_PUSH, OP_INJECT:
            begin
                if (full)
                    rsp_next.status = ST_FULL;
            end
            OP_POP:
            begin
                if (empty)
                    rsp_next.status = ST_EMPTY;
                else
                    rsp_next.value_out = cell_data[0];
            end
            OP_EJECT:
            begin
                if (empty)
                    rsp_next.status = ST_EMPTY;
                else
                    rsp_next.value_out = rear_word;
            end
            default:
                rsp_next.status = ST_OK;
        endcase
        if (!accept)
            rsp_next = rsp_reg;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
